[rtl/bitmap_slot_allocator_top_macros.svh]
// Assertion macros shared by the slot allocator modules.
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define BSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bsa_pkg.sv]
package bsa_pkg;

   localparam int SLOTS_DEFAULT = 64;

   // map row width; the map is stored as rows of this many bits
   localparam int ROW_BITS = 16;
   localparam int ROW_SH   = $clog2(ROW_BITS);

   localparam int OP_W     = 2;
   localparam int IDX_W    = 7;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 6;
   localparam int TOTAL_W  = 7;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

   typedef struct packed {
      logic accept;    // latch request, read its first row
      logic next_row;  // allocate scan: read the following row
      logic commit;    // update state and load the result register
   } bsa_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic found;     // current row has a free in-range slot
      logic last_row;
      logic out_free;  // result register can take a new result
   } bsa_sts_type;

endpackage

[rtl/bsa_ctrl.sv]
`include "bitmap_slot_allocator_top_macros.svh"
module bsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bsa_pkg::bsa_sts_type sts,
   output bsa_pkg::bsa_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_CHECK = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_alloc && !sts.found && !sts.last_row) begin
               cmd.next_row = 1'b1;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BSA_ASSERT_IMP(a_commit_room, clock, reset, cmd.commit, sts.out_free, "commit without room")
   `BSA_ASSERT_IMP(a_scan_bound, clock, reset, cmd.next_row, !sts.last_row, "scan past last row")
   `BSA_ASSERT_NXT(a_accept_busy, clock, reset, cmd.accept, !req_ready, "accepted twice in a row")

endmodule

[rtl/bsa_datapath.sv]
`include "bitmap_slot_allocator_top_macros.svh"
module bsa_datapath #(
   parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bsa_pkg::OP_W-1:0]       req_op,
   input  logic [bsa_pkg::IDX_W-1:0]      req_slot_index,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bsa_pkg::GRANT_W-1:0]    rsp_granted_slot,
   output logic [bsa_pkg::TOTAL_W-1:0]    rsp_used_total,
   input  bsa_pkg::bsa_cmd_type           cmd,
   output bsa_pkg::bsa_sts_type           sts
);

   localparam int RB     = bsa_pkg::ROW_BITS;
   localparam int RS     = bsa_pkg::ROW_SH;
   localparam int ROWS   = (SLOTS + RB - 1) / RB;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDXW   = (ROW_AW + RS > bsa_pkg::IDX_W) ? ROW_AW + RS : bsa_pkg::IDX_W;

   logic [RB-1:0] mem [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic [RB-1:0] rd_data_ff;
   logic          rd_valid_ff;

   logic [bsa_pkg::OP_W-1:0]  op_ff;
   logic [bsa_pkg::IDX_W-1:0] idx_ff;
   logic [ROW_AW-1:0]         row_ff;
   logic [ROW_AW-1:0]         row_in;
   logic                      active_ff;
   logic [bsa_pkg::TOTAL_W-1:0] count_ff;

   logic                           rsp_valid_ff;
   logic [bsa_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [bsa_pkg::GRANT_W-1:0]    rsp_granted_ff;
   logic [bsa_pkg::TOTAL_W-1:0]    rsp_total_ff;

   logic [IDXW-1:0]   req_wide;
   logic [IDXW-1:0]   idx_wide;
   logic              rd_en;
   logic [RB-1:0]     eff;
   logic [RB-1:0]     in_lim;
   logic [RB-1:0]     avail;
   logic [RS-1:0]     free_bit;
   logic [RS-1:0]     idx_bit;
   logic [ROW_AW+RS-1:0] slot_num;
   logic              idx_in_range;
   logic              free_ok;
   logic              wr_en;
   logic [RB-1:0]     wr_data;
   logic              clear_all;
   logic              active_in;
   logic [bsa_pkg::TOTAL_W-1:0]  count_in;
   logic [bsa_pkg::STATUS_W-1:0] status_in;
   logic [bsa_pkg::GRANT_W-1:0]  granted_in;
   logic [bsa_pkg::TOTAL_W-1:0]  total_in;

   assign req_wide = IDXW'(req_slot_index);
   assign idx_wide = IDXW'(idx_ff);
   assign idx_bit  = idx_ff[RS-1:0];
   assign rd_en    = cmd.accept | cmd.next_row;

   always_comb begin
      if (cmd.accept) begin
         row_in = (req_op == bsa_pkg::OP_FREE) ? req_wide[ROW_AW+RS-1:RS] : '0;
      end else begin
         row_in = row_ff + ROW_AW'(1);
      end
   end

   // unwritten rows read as all free
   assign eff = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      for (int b = 0; b < RB; b++) begin
         in_lim[b] = (32'({row_ff, RS'(b)}) < 32'(SLOTS));
      end
   end

   assign avail = ~eff & in_lim;

   always_comb begin
      free_bit = '0;
      for (int b = RB - 1; b >= 0; b--) begin
         if (avail[b]) begin
            free_bit = RS'(b);
         end
      end
   end

   assign slot_num     = {row_ff, free_bit};
   assign idx_in_range = (32'(idx_wide) < 32'(SLOTS));
   assign free_ok      = active_ff && idx_in_range && eff[idx_bit];

   assign sts.is_alloc = (op_ff == bsa_pkg::OP_ALLOC);
   assign sts.found    = |avail;
   assign sts.last_row = (row_ff == ROW_AW'(ROWS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_en      = 1'b0;
      wr_data    = eff;
      clear_all  = 1'b0;
      active_in  = active_ff;
      count_in   = count_ff;
      status_in  = bsa_pkg::ST_REJECT;
      granted_in = '0;
      total_in   = count_ff;
      case (op_ff)
         bsa_pkg::OP_ALLOC: begin
            active_in = 1'b1;
            if (|avail) begin
               wr_en      = 1'b1;
               wr_data    = eff | (RB'(1) << free_bit);
               count_in   = count_ff + bsa_pkg::TOTAL_W'(1);
               status_in  = bsa_pkg::ST_OK;
               granted_in = bsa_pkg::GRANT_W'(slot_num);
               total_in   = count_ff + bsa_pkg::TOTAL_W'(1);
            end else begin
               status_in = bsa_pkg::ST_FULL;
            end
         end
         bsa_pkg::OP_FREE: begin
            if (free_ok) begin
               wr_en     = 1'b1;
               wr_data   = eff & ~(RB'(1) << idx_bit);
               count_in  = count_ff - bsa_pkg::TOTAL_W'(1);
               status_in = bsa_pkg::ST_OK;
               total_in  = count_ff - bsa_pkg::TOTAL_W'(1);
            end
         end
         bsa_pkg::OP_RELEASE: begin
            // count always equals the used bits modulo 128
            clear_all = 1'b1;
            active_in = 1'b0;
            count_in  = '0;
            status_in = bsa_pkg::ST_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[row_in];
      end
      if (cmd.commit && wr_en) begin
         mem[row_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         idx_ff <= req_slot_index;
      end
      if (rd_en) begin
         row_ff <= row_in;
      end
      if (cmd.commit) begin
         rsp_status_ff  <= status_in;
         rsp_granted_ff <= granted_in;
         rsp_total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         active_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[row_in];
         end
         if (cmd.commit) begin
            active_ff <= active_in;
            count_ff  <= count_in;
            if (clear_all) begin
               row_valid_ff <= '0;
            end else if (wr_en) begin
               row_valid_ff[row_ff] <= 1'b1;
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_used_total   = rsp_total_ff;

   `BSA_ASSERT_NXT(a_release_clear, clock, reset, cmd.commit && op_ff == bsa_pkg::OP_RELEASE, count_ff == '0 && !active_ff && row_valid_ff == '0, "release left state")
   `BSA_ASSERT_NXT(a_alloc_active, clock, reset, cmd.commit && sts.is_alloc, active_ff, "allocate left inactive")
   `BSA_ASSERT_NXT(a_result_shown, clock, reset, cmd.commit, rsp_valid_ff, "result not presented")

endmodule

[rtl/bitmap_slot_allocator_top.sv]
// First-fit swap slot allocator.
// Request channel (req_valid/req_ready): req_op selects allocate, free or
// release all; req_slot_index names the slot to free.
// Result channel (rsp_valid/rsp_ready): one result per request with
// rsp_status, rsp_granted_slot and rsp_used_total.
// The used map is kept in rows of 16 bits in a small memory with a
// registered read port; each request reads one row per cycle.
// Free, release and the unused opcode load their result once the row read
// at the transfer is registered and the result register has room. Allocate
// first scans rows until a free slot is found or the last row is read.
// A new request is taken in the cycle after the result is loaded, so one
// request is in flight at a time.
// The result sits in an output register; while the receiver stalls the block
// still takes the next request and holds its result until the register
// drains.
// Reset is synchronous; per-row valid flags clear the whole map at once, so
// requests are taken from the first cycle after reset.
module bitmap_slot_allocator_top #(
   parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bsa_pkg::OP_W-1:0]       req_op,
   input  logic [bsa_pkg::IDX_W-1:0]      req_slot_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bsa_pkg::GRANT_W-1:0]    rsp_granted_slot,
   output logic [bsa_pkg::TOTAL_W-1:0]    rsp_used_total
);

   bsa_pkg::bsa_cmd_type cmd;
   bsa_pkg::bsa_sts_type sts;

   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsa_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_slot_index   (req_slot_index),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_used_total   (rsp_used_total),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
